// ===== src/i2c_register_access_master_core_defines.svh =====
// ----------------------------------------------------------------------------
// i2c register access master: assertion macros
// shared concurrent assertion helpers, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH

// same-cycle implication
`define I2CRAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CRAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cram_pkg
// types and codes shared by the i2c register access master
// ----------------------------------------------------------------------------
`default_nettype none

package i2cram_pkg;

    // item kinds
    localparam logic [1:0] KIND_WRITE     = 2'd0;
    localparam logic [1:0] KIND_READ_BYTE = 2'd1;
    localparam logic [1:0] KIND_READ_WORD = 2'd2;
    localparam logic [1:0] KIND_TICK      = 2'd3;

    // bus sequence segments, phase = segment * 4 + half
    localparam logic [3:0] SEG_IDLE      = 4'd0;
    localparam logic [3:0] SEG_START     = 4'd1;
    localparam logic [3:0] SEG_WADDR     = 4'd2;
    localparam logic [3:0] SEG_WADDR_ACK = 4'd3;
    localparam logic [3:0] SEG_REG       = 4'd4;
    localparam logic [3:0] SEG_REG_ACK   = 4'd5;
    localparam logic [3:0] SEG_DATA      = 4'd6;
    localparam logic [3:0] SEG_DATA_ACK  = 4'd7;
    localparam logic [3:0] SEG_RSTART    = 4'd8;
    localparam logic [3:0] SEG_RADDR     = 4'd9;
    localparam logic [3:0] SEG_RADDR_ACK = 4'd10;
    localparam logic [3:0] SEG_RX        = 4'd11;
    localparam logic [3:0] SEG_NACK      = 4'd12;
    localparam logic [3:0] SEG_STOP      = 4'd13;

    localparam logic [7:0] DEV_ADDR_RESET = 8'd208;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic [5:0] phase;
        logic [2:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] high_byte;
        logic [7:0] held_register;
        logic [7:0] held_write_data;
        logic [1:0] command_kind;
        logic       second_read;
    } state_t;

endpackage

`default_nettype wire

// ===== src/i2cram_step.sv =====
// ----------------------------------------------------------------------------
// i2cram_step
// one half-bit step of the bus sequencer: next state and bus levels
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_step (
    input  var i2cram_pkg::state_t    cur,
    input  var i2cram_pkg::in_item_t  item,
    input  var logic [7:0]            dev_addr,
    output i2cram_pkg::state_t        nxt,
    output i2cram_pkg::out_item_t     result
);
    import i2cram_pkg::*;

    logic [3:0] seg;
    logic [1:0] sub;
    logic [5:0] ph;
    logic [3:0] seg_after;
    logic [7:0] tx_byte;
    logic       bit_seg;
    logic       last;
    logic       scl;
    logic       sda;
    logic       done;
    logic [15:0] data;

    assign seg = cur.phase[5:2];
    assign sub = cur.phase[1:0];

    // byte shifted out in a send segment
    always_comb
    begin
        unique case (seg) inside
            SEG_WADDR: tx_byte = dev_addr;
            SEG_REG:   tx_byte = cur.held_register;
            SEG_DATA:  tx_byte = cur.held_write_data;
            default:   tx_byte = dev_addr + 8'd1;
        endcase
    end

    // segment that follows a finished one
    always_comb
    begin
        unique case (seg) inside
            SEG_REG_ACK:
                seg_after = (cur.command_kind == KIND_WRITE) ? SEG_DATA : SEG_RSTART;
            SEG_DATA_ACK, SEG_NACK:
                seg_after = SEG_STOP;
            default:
                seg_after = seg + 4'd1;
        endcase
    end

    assign bit_seg = (seg == SEG_WADDR) || (seg == SEG_REG) || (seg == SEG_DATA)
                  || (seg == SEG_RADDR) || (seg == SEG_RX);

    always_comb
    begin
        nxt  = cur;
        scl  = 1'b1;
        sda  = 1'b1;
        done = 1'b0;
        data = 16'h0000;
        last = 1'b0;
        ph   = ((seg == SEG_IDLE) || (seg > SEG_STOP)) ? 6'd0 : cur.phase;
        nxt.phase = ph;

        if (item.kind != KIND_TICK)
        begin
            // commands only start from idle
            if (ph == 6'd0)
            begin
                nxt.command_kind    = item.kind;
                nxt.held_register   = item.target_reg;
                nxt.held_write_data = item.write_data;
                nxt.second_read     = 1'b0;
                nxt.high_byte       = 8'h00;
                nxt.phase           = {SEG_START, 2'b00};
                nxt.bit_count       = 3'd0;
            end
        end
        else if (ph != 6'd0)
        begin
            unique case (seg) inside
                SEG_START:
                begin
                    scl  = 1'b1;
                    sda  = (sub == 2'd0);
                    last = (sub != 2'd0);
                end
                SEG_RSTART, SEG_STOP:
                begin
                    scl  = (sub != 2'd0);
                    if (sub == 2'd0 || sub == 2'd1)
                        sda = (seg != SEG_STOP);
                    else
                        sda = (seg == SEG_STOP);
                    last = (sub >= 2'd2);
                end
                SEG_WADDR, SEG_REG, SEG_DATA, SEG_RADDR:
                begin
                    sda = tx_byte[3'd7 - cur.bit_count];
                    scl = (sub != 2'd0);
                    if (sub != 2'd0)
                    begin
                        if (cur.bit_count == 3'd7)
                            last = 1'b1;
                        else
                            nxt.bit_count = cur.bit_count + 3'd1;
                    end
                end
                SEG_RX:
                begin
                    scl = (sub != 2'd0);
                    if (sub != 2'd0)
                    begin
                        nxt.shift_byte = {cur.shift_byte[6:0], item.sda_in};
                        if (cur.bit_count == 3'd7)
                            last = 1'b1;
                        else
                            nxt.bit_count = cur.bit_count + 3'd1;
                    end
                end
                default:
                begin
                    // ack slots and nack: line released
                    scl  = (sub != 2'd0);
                    last = (sub != 2'd0);
                end
            endcase

            if (!last)
            begin
                if (bit_seg && (sub != 2'd0))
                    nxt.phase = {seg, 2'b00};
                else
                    nxt.phase = {seg, 2'b00} | {3'b000, {1'b0, sub} + 3'd1};
            end
            else if (seg != SEG_STOP)
            begin
                nxt.phase     = {seg_after, 2'b00};
                nxt.bit_count = 3'd0;
                if (seg_after == SEG_RX)
                    nxt.shift_byte = 8'h00;
            end
            else if (cur.command_kind == KIND_READ_WORD && !cur.second_read)
            begin
                // first half of a word read done, go again at register + 1
                nxt.high_byte     = cur.shift_byte;
                nxt.second_read   = 1'b1;
                nxt.held_register = cur.held_register + 8'd1;
                nxt.phase         = {SEG_START, 2'b00};
                nxt.bit_count     = 3'd0;
            end
            else
            begin
                nxt.phase = 6'd0;
                done      = 1'b1;
                if (cur.command_kind == KIND_READ_BYTE)
                    data = {8'h00, cur.shift_byte};
                else if (cur.command_kind == KIND_READ_WORD)
                    data = {cur.high_byte, cur.shift_byte};
            end
        end
    end

    assign result.scl_level = scl;
    assign result.sda_level = sda;
    assign result.busy_res  = (nxt.phase != 6'd0);
    assign result.done_res  = done;
    assign result.read_data = data;

endmodule

`default_nettype wire

// ===== src/i2c_register_access_master_core.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master_core
// pin-level i2c master for register write, byte read and word read
// ----------------------------------------------------------------------------
// Each accepted item is either a command (write, byte read, word read) or a
// tick that stands for one half-bit period on the bus. Every item gives
// exactly one result: the scl/sda levels to hold for that half-period, busy,
// done, and on the done tick of a read the data (byte in the low bits, word
// as high:low). Commands given while a transaction runs are dropped; slave
// acks are clocked but not checked. The block takes one item per clock while
// results are taken: the item lands in an input register, and one pass of
// the step logic, run when the result register is free or draining, updates
// the sequencer state and loads the result register. While a result waits,
// the empty input register can still take one item; after that the input
// stalls until the result is taken. The device address register is written
// through cfg_write_en/cfg_write_data and should only change while no
// transaction is running.
`default_nettype none

module i2c_register_access_master_core (
    input  var logic                  clk,
    input  var logic                  rst_n,
    // configuration
    input  var logic                  cfg_write_en,
    input  var logic [7:0]            cfg_write_data,
    // item channel
    input  var logic                  item_valid,
    output logic                      item_ready,
    input  var i2cram_pkg::in_item_t  item,
    // result channel
    output logic                      result_valid,
    input  var logic                  result_ready,
    output i2cram_pkg::out_item_t     result
);
    import i2cram_pkg::*;

`include "i2c_register_access_master_core_defines.svh"

    // device write address
    logic [7:0] dev_addr_reg;

    // input register
    in_item_t  item_reg;
    logic      item_valid_reg;

    // sequencer state
    state_t    state_reg;
    state_t    state_next;

    // result register
    out_item_t result_reg;
    out_item_t result_next;
    logic      result_valid_reg;

    logic      item_take;
    logic      step_fire;

    // step runs when an item is staged and the result slot is free or draining
    assign step_fire  = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || step_fire;
    assign item_take  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_addr_reg <= DEV_ADDR_RESET;
        else if (cfg_write_en)
            dev_addr_reg <= cfg_write_data;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_ready)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
    end

    // one half-bit step of the sequencer
    i2cram_step u_step (
        .cur      (state_reg),
        .item     (item_reg),
        .dev_addr (dev_addr_reg),
        .nxt      (state_next),
        .result   (result_next)
    );

    // sequencer state only moves when a step completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step_fire)
            state_reg <= state_next;
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (step_fire)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a finished transaction never reports busy
    `I2CRAM_ASSERT_IMP(a_done_not_busy, result_valid_reg && result_reg.done_res,
        !result_reg.busy_res, "done result still busy")

    // read data only shows up on the done tick
    `I2CRAM_ASSERT_IMP(a_data_on_done, result_valid_reg && (result_reg.read_data != 16'h0000),
        result_reg.done_res, "read data outside done tick")

    // sequencer never leaves the known segments
    `I2CRAM_ASSERT_IMP(a_phase_known, 1'b1,
        state_reg.phase[5:2] <= SEG_STOP, "phase outside known segments")

    // a completed step always leaves a result behind
    `I2CRAM_ASSERT_NXT(a_step_result, step_fire,
        result_valid_reg, "step without result")

    // a staged item that cannot step is kept
    `I2CRAM_ASSERT_NXT(a_item_held, item_valid_reg && !step_fire,
        item_valid_reg && $stable(item_reg), "staged item lost")

endmodule

`default_nettype wire
